// ===== rtl/bwpb_pkg.sv =====
// Shared widths, codes, types and the channel mix function of the weighted pixel blend.
package bwpb_pkg;

  // Field widths of the request, the result and the configuration, and the fraction width.
  localparam int COORD_W    = 12;
  localparam int WEIGHT_W   = 17;
  localparam int CHAN_W     = 8;
  localparam int SCALE_W    = 24;
  localparam int DIAM_W     = 8;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Position product width: coordinate times inverse scale.
  localparam int POS_W = COORD_W + SCALE_W;

  // One in Q1.16.
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  // Request function codes.
  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_BLEND  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIAM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREY_SOURCE = 2'd3;

  // Configuration reset values.
  localparam logic [SCALE_W-1:0] INV_SCALE_RESET = 24'd65536;
  localparam logic [DIAM_W-1:0]  GRID_DIAM_RESET = 8'd128;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Blend one channel: (src*m + dst*(1-m)) >> 16, saturated to full scale.
  function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] src,
                                                    input logic [CHAN_W-1:0] dst,
                                                    input logic [WEIGHT_W-1:0] m);
    logic [WEIGHT_W-1:0] inv_m;
    logic [25:0]         sum;
    logic [9:0]          val;
    inv_m = ONE_Q16 - m;
    sum   = 26'(src) * 26'(m) + 26'(dst) * 26'(inv_m);
    val   = sum[25:16];
    mix_channel = (val > 10'd255) ? 8'hFF : val[CHAN_W-1:0];
  endfunction

endpackage

// ===== rtl/bilinear_weighted_pixel_blend.sv =====
// Top level of the bilinearly weighted pixel blend pipeline.
// A blend request passes stages 1 to 4 and the output register before it reaches the result ports.
// Throughput: one request per cycle; each stage stalls only when the next one is full.
// Weight writes take one slot, commit as they leave stage 1 and give no result.
// Reset clears the stage valid bits and the configuration registers.
// The weight grid is not cleared by reset; entries are undefined until written.
module bilinear_weighted_pixel_blend #(
  parameter int MAX_RADIUS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [bwpb_pkg::COORD_W-1:0]      col_i,
  input  logic [bwpb_pkg::COORD_W-1:0]      row_i,
  input  logic [bwpb_pkg::WEIGHT_W-1:0]     weight_value_i,
  input  logic [bwpb_pkg::CHAN_W-1:0]       dst_red_i,
  input  logic [bwpb_pkg::CHAN_W-1:0]       dst_green_i,
  input  logic [bwpb_pkg::CHAN_W-1:0]       dst_blue_i,
  input  logic [bwpb_pkg::CHAN_W-1:0]       src_red_i,
  input  logic [bwpb_pkg::CHAN_W-1:0]       src_green_i,
  input  logic [bwpb_pkg::CHAN_W-1:0]       src_blue_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bwpb_pkg::CHAN_W-1:0]       out_red_o,
  output logic [bwpb_pkg::CHAN_W-1:0]       out_green_o,
  output logic [bwpb_pkg::CHAN_W-1:0]       out_blue_o,
  output logic                              blended_o,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [bwpb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bwpb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int GRID_SIDE  = 2 * MAX_RADIUS;
  localparam int IDX_W      = $clog2(GRID_SIDE);
  localparam int HALF_W     = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int FRAC_W     = bwpb_pkg::FRAC_W;
  localparam int POS_W      = bwpb_pkg::POS_W;
  localparam int INT_W      = POS_W - FRAC_W;
  localparam int WEIGHT_W   = bwpb_pkg::WEIGHT_W;
  localparam int DIAM_W     = bwpb_pkg::DIAM_W;
  localparam int AB_W       = WEIGHT_W + FRAC_W;
  localparam int MAG_W      = WEIGHT_W + 2 * FRAC_W;

  // Configuration registers.
  logic [bwpb_pkg::SCALE_W-1:0] inv_scale_x_q;
  logic [bwpb_pkg::SCALE_W-1:0] inv_scale_y_q;
  logic [DIAM_W-1:0]            grid_diam_q;
  logic                         grey_source_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_scale_x_q <= bwpb_pkg::INV_SCALE_RESET;
      inv_scale_y_q <= bwpb_pkg::INV_SCALE_RESET;
      grid_diam_q   <= bwpb_pkg::GRID_DIAM_RESET;
      grey_source_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bwpb_pkg::CFG_INV_SCALE_X: inv_scale_x_q <= cfg_data_i;
        bwpb_pkg::CFG_INV_SCALE_Y: inv_scale_y_q <= cfg_data_i;
        bwpb_pkg::CFG_GRID_DIAM:   grid_diam_q   <= cfg_data_i[DIAM_W-1:0];
        bwpb_pkg::CFG_GREY_SOURCE: grey_source_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic en1, en2, en3, en4, en_out;

  assign en_out     = !out_valid_q || out_ready_i;
  assign en4        = !s4_valid_q || en_out;
  assign en3        = !s3_valid_q || en4;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // Stage 1: scale the position into grid units.
  logic                         s1_func_q;
  logic [bwpb_pkg::COORD_W-1:0] s1_col_q, s1_row_q;
  logic [WEIGHT_W-1:0]          s1_weight_q;
  logic [POS_W-1:0]             s1_px_q, s1_py_q;
  bwpb_pkg::rgb_t               s1_dst_q, s1_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_func_q   <= func_i;
      s1_col_q    <= col_i;
      s1_row_q    <= row_i;
      s1_weight_q <= weight_value_i;
      s1_px_q     <= POS_W'(col_i) * POS_W'(inv_scale_x_q);
      s1_py_q     <= POS_W'(row_i) * POS_W'(inv_scale_y_q);
      s1_dst_q    <= '{red: dst_red_i, green: dst_green_i, blue: dst_blue_i};
      s1_src_q    <= '{red: src_red_i, green: src_green_i, blue: src_blue_i};
    end
  end

  // Stage 1 logic: grid coordinates, edge clamp and bank addressing.
  logic [DIAM_W-1:0] diam;
  logic [INT_W-1:0]  x_int, y_int;
  logic              s1_hit;
  logic [IDX_W-1:0]  x1, y1, x2, y2;
  logic [IDX_W:0]    x1_inc, y1_inc;
  logic [IDX_W-1:0]  col_sel [2];
  logic [IDX_W-1:0]  row_sel [2];
  logic              wr_in_range, wr_commit;
  logic [IDX_W-1:0]  wr_col, wr_row;
  logic [BANK_AW-1:0] wr_addr;

  always_comb begin
    diam   = (grid_diam_q > DIAM_W'(GRID_SIDE)) ? DIAM_W'(GRID_SIDE) : grid_diam_q;
    x_int  = s1_px_q[POS_W-1:FRAC_W];
    y_int  = s1_py_q[POS_W-1:FRAC_W];
    s1_hit = (x_int < INT_W'(diam)) && (y_int < INT_W'(diam));
    x1     = s1_px_q[FRAC_W +: IDX_W];
    y1     = s1_py_q[FRAC_W +: IDX_W];
    x1_inc = (IDX_W+1)'(x1) + 1'b1;
    y1_inc = (IDX_W+1)'(y1) + 1'b1;
    x2     = (DIAM_W'(x1_inc) >= diam) ? x1 : x1_inc[IDX_W-1:0];
    y2     = (DIAM_W'(y1_inc) >= diam) ? y1 : y1_inc[IDX_W-1:0];
    // Each bank of a given parity serves whichever neighbor has that parity.
    for (int p = 0; p < 2; p++) begin
      col_sel[p] = (x1[0] == 1'(p)) ? x1 : x2;
      row_sel[p] = (y1[0] == 1'(p)) ? y1 : y2;
    end
  end

  // Weight write: commits as the write request leaves stage 1.
  assign wr_in_range = (s1_col_q < bwpb_pkg::COORD_W'(GRID_SIDE)) &&
                       (s1_row_q < bwpb_pkg::COORD_W'(GRID_SIDE));
  assign wr_commit   = s1_valid_q && (s1_func_q == bwpb_pkg::FUNC_WEIGHT) &&
                       wr_in_range && en2;
  assign wr_col      = s1_col_q[IDX_W-1:0];
  assign wr_row      = s1_row_q[IDX_W-1:0];
  assign wr_addr     = {HALF_W'(wr_col >> 1), HALF_W'(wr_row >> 1)};

  // Four banks split by column and row parity, so all neighbors read at once.
  logic [WEIGHT_W-1:0] bank_rdata [2][2];

  for (genvar gx = 0; gx < 2; gx++) begin : g_bank_x
    for (genvar gy = 0; gy < 2; gy++) begin : g_bank_y
      logic               bank_we;
      logic [BANK_AW-1:0] bank_raddr;

      assign bank_we    = wr_commit && (wr_col[0] == 1'(gx)) && (wr_row[0] == 1'(gy));
      assign bank_raddr = {HALF_W'(col_sel[gx] >> 1), HALF_W'(row_sel[gy] >> 1)};

      bwpb_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (BANK_DEPTH)
      ) u_bank (
        .clk_i   (clk_i),
        .we_i    (bank_we),
        .waddr_i (wr_addr),
        .wdata_i (s1_weight_q),
        .re_i    (en2),
        .raddr_i (bank_raddr),
        .rdata_o (bank_rdata[gx][gy])
      );
    end
  end

  // Stage 2: only blend requests continue past the grid read.
  logic              s2_hit_q;
  logic [FRAC_W-1:0] s2_fx_q, s2_fy_q;
  logic              s2_x1b_q, s2_x2b_q, s2_y1b_q, s2_y2b_q;
  bwpb_pkg::rgb_t    s2_dst_q, s2_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q && (s1_func_q == bwpb_pkg::FUNC_BLEND);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_hit_q <= s1_hit;
      s2_fx_q  <= s1_px_q[FRAC_W-1:0];
      s2_fy_q  <= s1_py_q[FRAC_W-1:0];
      s2_x1b_q <= x1[0];
      s2_x2b_q <= x2[0];
      s2_y1b_q <= y1[0];
      s2_y2b_q <= y2[0];
      s2_dst_q <= s1_dst_q;
      s2_src_q <= s1_src_q;
    end
  end

  // Stage 2 logic: interpolate along y for both columns.
  logic [WEIGHT_W-1:0] w11, w12, w21, w22, inv_fy;
  logic [AB_W:0]       a_full, b_full;
  logic [AB_W-1:0]     s3_a_d, s3_b_d;

  always_comb begin
    w11    = bank_rdata[s2_x1b_q][s2_y1b_q];
    w12    = bank_rdata[s2_x1b_q][s2_y2b_q];
    w21    = bank_rdata[s2_x2b_q][s2_y1b_q];
    w22    = bank_rdata[s2_x2b_q][s2_y2b_q];
    inv_fy = bwpb_pkg::ONE_Q16 - WEIGHT_W'(s2_fy_q);
    a_full = (AB_W+1)'(w12) * (AB_W+1)'(s2_fy_q) + (AB_W+1)'(w11) * (AB_W+1)'(inv_fy);
    b_full = (AB_W+1)'(w22) * (AB_W+1)'(s2_fy_q) + (AB_W+1)'(w21) * (AB_W+1)'(inv_fy);
    // Outside the grid the weight is zero, which later reads as no blend.
    s3_a_d = s2_hit_q ? a_full[AB_W-1:0] : '0;
    s3_b_d = s2_hit_q ? b_full[AB_W-1:0] : '0;
  end

  // Stage 3: interpolated y results.
  logic [AB_W-1:0]   s3_a_q, s3_b_q;
  logic [FRAC_W-1:0] s3_fx_q;
  bwpb_pkg::rgb_t    s3_dst_q, s3_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_a_q   <= s3_a_d;
      s3_b_q   <= s3_b_d;
      s3_fx_q  <= s2_fx_q;
      s3_dst_q <= s2_dst_q;
      s3_src_q <= s2_src_q;
    end
  end

  // Stage 3 logic: interpolate along x and saturate the blend weight.
  logic [WEIGHT_W-1:0] inv_fx, m_int, s4_m_d;
  logic [MAG_W:0]      mag_full;
  logic [MAG_W-1:0]    mag;

  always_comb begin
    inv_fx   = bwpb_pkg::ONE_Q16 - WEIGHT_W'(s3_fx_q);
    mag_full = (MAG_W+1)'(s3_b_q) * (MAG_W+1)'(s3_fx_q) +
               (MAG_W+1)'(s3_a_q) * (MAG_W+1)'(inv_fx);
    mag      = mag_full[MAG_W-1:0];
    m_int    = mag[MAG_W-1:2*FRAC_W];
    s4_m_d   = (m_int > bwpb_pkg::ONE_Q16) ? bwpb_pkg::ONE_Q16 : m_int;
  end

  // Stage 4: blend weight and flag.
  logic [WEIGHT_W-1:0] s4_m_q;
  logic                s4_blend_q;
  bwpb_pkg::rgb_t      s4_dst_q, s4_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en4) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_m_q     <= s4_m_d;
      s4_blend_q <= |mag;
      s4_dst_q   <= s3_dst_q;
      s4_src_q   <= s3_src_q;
    end
  end

  // Stage 4 logic: per-channel mix, grey sources use red for all channels.
  bwpb_pkg::rgb_t src_eff, mixed, out_d;

  always_comb begin
    src_eff.red   = s4_src_q.red;
    src_eff.green = grey_source_q ? s4_src_q.red : s4_src_q.green;
    src_eff.blue  = grey_source_q ? s4_src_q.red : s4_src_q.blue;
    mixed.red     = bwpb_pkg::mix_channel(src_eff.red,   s4_dst_q.red,   s4_m_q);
    mixed.green   = bwpb_pkg::mix_channel(src_eff.green, s4_dst_q.green, s4_m_q);
    mixed.blue    = bwpb_pkg::mix_channel(src_eff.blue,  s4_dst_q.blue,  s4_m_q);
    out_d         = s4_blend_q ? mixed : s4_dst_q;
  end

  // Output register.
  bwpb_pkg::rgb_t out_pix_q;
  logic           out_blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_pix_q   <= out_d;
      out_blend_q <= s4_blend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_pix_q.red;
  assign out_green_o = out_pix_q.green;
  assign out_blue_o  = out_pix_q.blue;
  assign blended_o   = out_blend_q;

endmodule

// ===== rtl/bwpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bwpb_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bwpb_checker.sv =====
// Port-level checker for the weighted pixel blend, bound to the top level.
module bwpb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bwpb_pkg::CHAN_W-1:0] out_red_o,
  input logic [bwpb_pkg::CHAN_W-1:0] out_green_o,
  input logic [bwpb_pkg::CHAN_W-1:0] out_blue_o,
  input logic                        blended_o
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped before it was taken");

  // A result that is not taken keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o) &&
      $stable(blended_o))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline by the following edge.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // With the output register empty, no stage can hold back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled although the output register is empty");

endmodule

bind bilinear_weighted_pixel_blend bwpb_checker u_bwpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_red_o   (out_red_o),
  .out_green_o (out_green_o),
  .out_blue_o  (out_blue_o),
  .blended_o   (blended_o)
);

// ===== tb/bilinear_weighted_pixel_blend_tb.sv =====
// Self-checking testbench for the bilinearly weighted pixel blend.
`timescale 1ns / 1ps

module bilinear_weighted_pixel_blend_tb;

  localparam int GRID_SIDE   = 128;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic                          func;
    logic [bwpb_pkg::COORD_W-1:0]  col;
    logic [bwpb_pkg::COORD_W-1:0]  row;
    logic [bwpb_pkg::WEIGHT_W-1:0] weight;
    bwpb_pkg::rgb_t                dst;
    bwpb_pkg::rgb_t                src;
  } pixel_req_t;

  typedef struct packed {
    bwpb_pkg::rgb_t color;
    logic           blended;
  } pixel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic                            func_i = bwpb_pkg::FUNC_WEIGHT;
  logic [bwpb_pkg::COORD_W-1:0]    col_i = '0;
  logic [bwpb_pkg::COORD_W-1:0]    row_i = '0;
  logic [bwpb_pkg::WEIGHT_W-1:0]   weight_value_i = '0;
  logic [bwpb_pkg::CHAN_W-1:0]     dst_red_i = '0;
  logic [bwpb_pkg::CHAN_W-1:0]     dst_green_i = '0;
  logic [bwpb_pkg::CHAN_W-1:0]     dst_blue_i = '0;
  logic [bwpb_pkg::CHAN_W-1:0]     src_red_i = '0;
  logic [bwpb_pkg::CHAN_W-1:0]     src_green_i = '0;
  logic [bwpb_pkg::CHAN_W-1:0]     src_blue_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [bwpb_pkg::CHAN_W-1:0]     out_red_o;
  logic [bwpb_pkg::CHAN_W-1:0]     out_green_o;
  logic [bwpb_pkg::CHAN_W-1:0]     out_blue_o;
  logic                            blended_o;
  logic                            cfg_we_i = 1'b0;
  logic [bwpb_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [bwpb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow copy of the configuration and of the weight grid.
  logic [bwpb_pkg::SCALE_W-1:0]  cfg_sx = bwpb_pkg::INV_SCALE_RESET;
  logic [bwpb_pkg::SCALE_W-1:0]  cfg_sy = bwpb_pkg::INV_SCALE_RESET;
  logic [bwpb_pkg::DIAM_W-1:0]   cfg_diam = bwpb_pkg::GRID_DIAM_RESET;
  logic                          cfg_grey = 1'b0;
  logic [bwpb_pkg::WEIGHT_W-1:0] weight_grid [GRID_SIDE*GRID_SIDE];
  // Grid entries that some queued request will have written.
  bit                            cell_loaded [GRID_SIDE*GRID_SIDE];

  pixel_req_t pending_reqs [$];
  pixel_out_t expected_pix [$];
  pixel_req_t cur_req;
  int unsigned issued_reqs = 0;
  int unsigned accepted_reqs = 0;
  int unsigned stim_items = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  wire         calm = (cycle_count >= 1500) && (cycle_count < 2500);

  bilinear_weighted_pixel_blend #(
    .MAX_RADIUS(64)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .weight_value_i (weight_value_i),
    .dst_red_i      (dst_red_i),
    .dst_green_i    (dst_green_i),
    .dst_blue_i     (dst_blue_i),
    .src_red_i      (src_red_i),
    .src_green_i    (src_green_i),
    .src_blue_i     (src_blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .blended_o      (blended_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Map a pixel position to its grid cell, neighbors and fractions; returns 1 if it is in the grid.
  function automatic bit locate_cell(input logic [bwpb_pkg::COORD_W-1:0] col,
                                     input logic [bwpb_pkg::COORD_W-1:0] row,
                                     output logic [6:0] x1, output logic [6:0] y1,
                                     output logic [6:0] x2, output logic [6:0] y2,
                                     output logic [bwpb_pkg::FRAC_W-1:0] fx,
                                     output logic [bwpb_pkg::FRAC_W-1:0] fy);
    logic [bwpb_pkg::POS_W-1:0] px;
    logic [bwpb_pkg::POS_W-1:0] py;
    logic [8:0]                 dc;
    dc = (cfg_diam > bwpb_pkg::DIAM_W'(GRID_SIDE)) ? 9'(GRID_SIDE) : {1'b0, cfg_diam};
    px = bwpb_pkg::POS_W'(col) * bwpb_pkg::POS_W'(cfg_sx);
    py = bwpb_pkg::POS_W'(row) * bwpb_pkg::POS_W'(cfg_sy);
    fx = px[bwpb_pkg::FRAC_W-1:0];
    fy = py[bwpb_pkg::FRAC_W-1:0];
    x1 = px[22:16];
    y1 = py[22:16];
    x2 = (9'(x1) + 9'd1 >= dc) ? x1 : x1 + 7'd1;
    y2 = (9'(y1) + 9'd1 >= dc) ? y1 : y1 + 7'd1;
    return (px[bwpb_pkg::POS_W-1:16] < 20'(dc)) && (py[bwpb_pkg::POS_W-1:16] < 20'(dc));
  endfunction

  // Weighted mix of one channel, truncated and saturated.
  function automatic logic [bwpb_pkg::CHAN_W-1:0] weigh_channel(
      input logic [bwpb_pkg::CHAN_W-1:0] s,
      input logic [bwpb_pkg::CHAN_W-1:0] d,
      input logic [bwpb_pkg::WEIGHT_W-1:0] m);
    logic [31:0] v;
    v = (32'(s) * 32'(m) + 32'(d) * (32'h10000 - 32'(m))) >> 16;
    return (v > 32'd255) ? 8'hFF : v[bwpb_pkg::CHAN_W-1:0];
  endfunction

  // Expected result of one blend request under the current grid and configuration.
  function automatic pixel_out_t blend_pixel(input pixel_req_t req);
    pixel_out_t                    r;
    logic [6:0]                    x1, y1, x2, y2;
    logic [bwpb_pkg::FRAC_W-1:0]   fx, fy;
    logic [63:0]                   a, b, mag;
    logic [bwpb_pkg::WEIGHT_W-1:0] m;
    bwpb_pkg::rgb_t                s;
    r.color = req.dst;
    r.blended = 1'b0;
    if (locate_cell(req.col, req.row, x1, y1, x2, y2, fx, fy)) begin
      a = 64'(weight_grid[{x1, y2}]) * fy + 64'(weight_grid[{x1, y1}]) * (64'h10000 - fy);
      b = 64'(weight_grid[{x2, y2}]) * fy + 64'(weight_grid[{x2, y1}]) * (64'h10000 - fy);
      mag = b * fx + a * (64'h10000 - fx);
      if (mag != 64'd0) begin
        m = (mag[63:32] > 32'h10000) ? bwpb_pkg::ONE_Q16 : mag[48:32];
        s = req.src;
        if (cfg_grey) begin
          s.green = s.red;
          s.blue = s.red;
        end
        r.color.red = weigh_channel(s.red, req.dst.red, m);
        r.color.green = weigh_channel(s.green, req.dst.green, m);
        r.color.blue = weigh_channel(s.blue, req.dst.blue, m);
        r.blended = 1'b1;
      end
    end
    return r;
  endfunction

  // Update the shadow grid or queue the expected pixel for an accepted request.
  task automatic apply_request(input pixel_req_t req);
    if (req.func == bwpb_pkg::FUNC_WEIGHT) begin
      if (req.col < GRID_SIDE && req.row < GRID_SIDE)
        weight_grid[{req.col[6:0], req.row[6:0]}] = req.weight;
    end else begin
      expected_pix.push_back(blend_pixel(req));
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("tb: mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic logic [bwpb_pkg::WEIGHT_W-1:0] rand_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return bwpb_pkg::ONE_Q16;
    if (r < 30) return '1;
    return bwpb_pkg::WEIGHT_W'($urandom_range(131071));
  endfunction

  function automatic bwpb_pkg::rgb_t rand_rgb();
    return bwpb_pkg::rgb_t'((3*bwpb_pkg::CHAN_W)'($urandom));
  endfunction

  // Pick a pixel coordinate, mostly within reach of the grid at the given scale.
  function automatic logic [bwpb_pkg::COORD_W-1:0] pick_coord(
      input logic [bwpb_pkg::SCALE_W-1:0] scale);
    longint unsigned lim;
    longint unsigned dc;
    dc = (cfg_diam > bwpb_pkg::DIAM_W'(GRID_SIDE)) ? GRID_SIDE : cfg_diam;
    lim = (scale == 0) ? 4095 : ((dc + 1) * 65536) / scale;
    if (lim > 4095) lim = 4095;
    if ($urandom_range(99) < 75) return bwpb_pkg::COORD_W'($urandom_range(int'(lim)));
    return bwpb_pkg::COORD_W'($urandom_range(4095));
  endfunction

  task automatic push_write(input int unsigned col, input int unsigned row,
                            input logic [bwpb_pkg::WEIGHT_W-1:0] w);
    pixel_req_t req;
    req = '0;
    req.func = bwpb_pkg::FUNC_WEIGHT;
    req.col = bwpb_pkg::COORD_W'(col);
    req.row = bwpb_pkg::COORD_W'(row);
    req.weight = w;
    req.dst = rand_rgb();
    req.src = rand_rgb();
    pending_reqs.push_back(req);
    issued_reqs++;
    if (col < GRID_SIDE && row < GRID_SIDE) begin
      cell_loaded[col*GRID_SIDE + row] = 1'b1;
      stim_items++;
    end
  endtask

  // Queue a blend request, first loading any neighbor cell it would read that is still empty.
  task automatic push_pixel(input int unsigned col, input int unsigned row,
                            input bwpb_pkg::rgb_t dst, input bwpb_pkg::rgb_t src);
    pixel_req_t                  req;
    logic [6:0]                  x1, y1, x2, y2;
    logic [bwpb_pkg::FRAC_W-1:0] fx, fy;
    if (locate_cell(bwpb_pkg::COORD_W'(col), bwpb_pkg::COORD_W'(row),
                    x1, y1, x2, y2, fx, fy)) begin
      if (!cell_loaded[{x1, y1}]) push_write(x1, y1, rand_weight());
      if (!cell_loaded[{x1, y2}]) push_write(x1, y2, rand_weight());
      if (!cell_loaded[{x2, y1}]) push_write(x2, y1, rand_weight());
      if (!cell_loaded[{x2, y2}]) push_write(x2, y2, rand_weight());
    end
    req = '0;
    req.func = bwpb_pkg::FUNC_BLEND;
    req.col = bwpb_pkg::COORD_W'(col);
    req.row = bwpb_pkg::COORD_W'(row);
    req.weight = bwpb_pkg::WEIGHT_W'($urandom);
    req.dst = dst;
    req.src = src;
    pending_reqs.push_back(req);
    issued_reqs++;
    stim_items++;
  endtask

  // Hold off new requests until every queued request has been answered and the pipe is empty.
  task automatic wait_settled();
    while (accepted_reqs != issued_reqs || expected_pix.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bwpb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bwpb_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      bwpb_pkg::CFG_INV_SCALE_X: cfg_sx = data;
      bwpb_pkg::CFG_INV_SCALE_Y: cfg_sy = data;
      bwpb_pkg::CFG_GRID_DIAM: cfg_diam = data[bwpb_pkg::DIAM_W-1:0];
      bwpb_pkg::CFG_GREY_SOURCE: cfg_grey = data[0];
      default: ;
    endcase
  endtask

  // One setting: drain, reprogram every register, then a random mix of writes and blends.
  task automatic run_setting(input logic [bwpb_pkg::SCALE_W-1:0] sx,
                             input logic [bwpb_pkg::SCALE_W-1:0] sy,
                             input logic [bwpb_pkg::DIAM_W-1:0] diam, input logic grey,
                             input int unsigned n);
    int unsigned goal;
    int unsigned col;
    int unsigned row;
    wait_settled();
    write_reg(bwpb_pkg::CFG_INV_SCALE_X, sx);
    write_reg(bwpb_pkg::CFG_INV_SCALE_Y, sy);
    write_reg(bwpb_pkg::CFG_GRID_DIAM, bwpb_pkg::CFG_DATA_W'(diam));
    write_reg(bwpb_pkg::CFG_GREY_SOURCE, bwpb_pkg::CFG_DATA_W'(grey));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    goal = stim_items + n;
    while (stim_items < goal) begin
      if ($urandom_range(99) < 12) begin
        col = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(GRID_SIDE-1);
        row = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(GRID_SIDE-1);
        push_write(col, row, rand_weight());
      end else begin
        push_pixel(pick_coord(cfg_sx), pick_coord(cfg_sy), rand_rgb(), rand_rgb());
      end
    end
  endtask

  // Request driver: holds each request until it is taken, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        accepted_reqs++;
        apply_request(cur_req);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
          cur_req = pending_reqs.pop_front();
          func_i <= cur_req.func;
          col_i <= cur_req.col;
          row_i <= cur_req.row;
          weight_value_i <= cur_req.weight;
          dst_red_i <= cur_req.dst.red;
          dst_green_i <= cur_req.dst.green;
          dst_blue_i <= cur_req.dst.blue;
          src_red_i <= cur_req.src.red;
          src_green_i <= cur_req.src.green;
          src_blue_i <= cur_req.src.blue;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each pixel against the oldest expectation and paces ready.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_pix.size() == 0) begin
          report_mismatch("unexpected pixel, red", 32'(out_red_o), 32'd0);
        end else begin
          want = expected_pix.pop_front();
          if (out_red_o !== want.color.red)
            report_mismatch("red", 32'(out_red_o), 32'(want.color.red));
          if (out_green_o !== want.color.green)
            report_mismatch("green", 32'(out_green_o), 32'(want.color.green));
          if (out_blue_o !== want.color.blue)
            report_mismatch("blue", 32'(out_blue_o), 32'(want.color.blue));
          if (blended_o !== want.blended)
            report_mismatch("blended", 32'(blended_o), 32'(want.blended));
        end
      end
      // One long hold-off so the pipe fills and pushes back on the request side.
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (results_seen >= 200 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset configuration.
    push_write(0, 0, bwpb_pkg::ONE_Q16);
    push_write(0, 1, bwpb_pkg::ONE_Q16);
    push_write(1, 0, bwpb_pkg::ONE_Q16);
    push_write(1, 1, bwpb_pkg::ONE_Q16);
    push_pixel(0, 0, 24'h000000, 24'hFFFFFF);
    push_pixel(0, 0, 24'hFFFFFF, 24'h000000);
    // Zero weight at the far corner, where both neighbors clamp to the edge.
    push_write(127, 127, '0);
    push_pixel(127, 127, 24'h5A3CC3, 24'hFFFFFF);
    // Weight above one saturates the blend.
    push_write(2, 2, '1);
    push_pixel(2, 2, 24'h102030, 24'hF0E0D0);
    // Writes outside the grid are dropped.
    push_write(4095, 4095, '1);
    push_write(5, 4000, bwpb_pkg::ONE_Q16);
    push_write(5, 5, 17'h08000);
    push_pixel(5, 5, 24'hFF00FF, 24'h00FF00);
    // Pixels outside the grid pass through.
    push_pixel(128, 0, 24'hFFFFFF, 24'h000000);
    push_pixel(0, 4095, 24'h123456, 24'hABCDEF);
    push_pixel(4095, 4095, 24'hFFFFFF, 24'hFFFFFF);

    // Extremes of the configuration, then random settings.
    run_setting(24'h008000, 24'h018000, 8'd8, 1'b0, 200);
    run_setting(24'h000001, 24'hFFFFFF, 8'd2, 1'b1, 120);
    run_setting(24'hFFFFFF, 24'h000001, 8'd128, 1'b0, 120);
    run_setting(24'h000000, 24'h000000, 8'd0, 1'b1, 60);
    run_setting(24'h000000, 24'd40000, 8'd255, 1'b0, 100);
    run_setting(24'd70000, 24'd20000, 8'd1, 1'b1, 80);
    repeat (6) begin
      run_setting(bwpb_pkg::SCALE_W'($urandom_range(262143, 1)),
                  bwpb_pkg::SCALE_W'($urandom_range(262143, 1)),
                  bwpb_pkg::DIAM_W'($urandom_range(128, 2)), 1'($urandom), 160);
    end

    wait_settled();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bilinear_weighted_pixel_blend.f =====
rtl/bwpb_pkg.sv
rtl/bwpb_ram.sv
rtl/bilinear_weighted_pixel_blend.sv
rtl/bwpb_checker.sv
tb/bilinear_weighted_pixel_blend_tb.sv
